// File: rtl/taabb_pkg.sv
package taabb_pkg;

    localparam int unsigned VAL_W  = 32;
    localparam int unsigned PROD_W = 64;
    localparam int unsigned FRAC_W = 16;
    localparam int unsigned TERM_W = PROD_W - FRAC_W;
    localparam int unsigned SUM_W  = TERM_W + 2;
    localparam int unsigned NAXES  = 3;

    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_W - 1);
    localparam logic [VAL_W-1:0]  SAT_POS    = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0]  SAT_NEG    = {1'b1, {(VAL_W-1){1'b0}}};

    localparam logic [1:0] ROW_X    = 2'd0;
    localparam logic [1:0] ROW_Y    = 2'd1;
    localparam logic [1:0] ROW_Z    = 2'd2;
    localparam logic [1:0] ROW_NONE = 2'd3;

    localparam logic [2:0] REG_MIN_X = 3'd0;
    localparam logic [2:0] REG_MIN_Y = 3'd1;
    localparam logic [2:0] REG_MIN_Z = 3'd2;
    localparam logic [2:0] REG_MAX_X = 3'd3;
    localparam logic [2:0] REG_MAX_Y = 3'd4;
    localparam logic [2:0] REG_MAX_Z = 3'd5;

    typedef logic [NAXES-1:0][VAL_W-1:0] vec_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] row;
        logic       last;
        vec_t       coef;
        logic [VAL_W-1:0] offset;
    } row_req_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] row;
        logic       last;
        logic       box_ok;
        logic [VAL_W-1:0] offset;
        logic [NAXES-1:0][PROD_W-1:0] pmin;
        logic [NAXES-1:0][PROD_W-1:0] pmax;
    } prod_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] row;
        logic       last;
        logic       box_ok;
        logic [VAL_W-1:0] lo;
        logic [VAL_W-1:0] hi;
    } range_t;

endpackage

// File: rtl/taabb_mult.sv
module taabb_mult
    import taabb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     advance,
    input  row_req_t req,
    input  vec_t     local_min,
    input  vec_t     local_max,
    output prod_t    prod
);

    prod_t prod_reg;
    prod_t prod_next;

    logic signed [VAL_W-1:0]  c_s [NAXES];
    logic signed [VAL_W-1:0]  lmin_s [NAXES];
    logic signed [VAL_W-1:0]  lmax_s [NAXES];
    logic signed [PROD_W-1:0] pmin_s [NAXES];
    logic signed [PROD_W-1:0] pmax_s [NAXES];
    logic box_ok;

    always_comb
    begin
        box_ok = 1'b1;
        for (int i = 0; i < NAXES; i++)
        begin
            c_s[i]    = $signed(req.coef[i]);
            lmin_s[i] = $signed(local_min[i]);
            lmax_s[i] = $signed(local_max[i]);
            pmin_s[i] = c_s[i] * lmin_s[i];
            pmax_s[i] = c_s[i] * lmax_s[i];
            if (lmin_s[i] > lmax_s[i])
            begin
                box_ok = 1'b0;
            end
        end
        prod_next.valid  = req.valid && (req.row != ROW_NONE);
        prod_next.row    = req.row;
        prod_next.last   = req.last;
        prod_next.box_ok = box_ok;
        prod_next.offset = req.offset;
        for (int i = 0; i < NAXES; i++)
        begin
            prod_next.pmin[i] = pmin_s[i];
            prod_next.pmax[i] = pmax_s[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_reg <= '0;
        end
        else if (advance)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

// File: rtl/taabb_reduce.sv
module taabb_reduce
    import taabb_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   advance,
    input  prod_t  prod,
    output range_t rng
);

    range_t rng_reg;
    range_t rng_next;

    logic signed [PROD_W-1:0] pa;
    logic signed [PROD_W-1:0] pb;
    logic signed [TERM_W-1:0] ta;
    logic signed [TERM_W-1:0] tb;
    logic signed [SUM_W-1:0]  lo_sum;
    logic signed [SUM_W-1:0]  hi_sum;

    function automatic logic [VAL_W-1:0] sat32(input logic [SUM_W-1:0] v);
        logic [SUM_W-VAL_W:0] top;
        top = v[SUM_W-1:VAL_W-1];
        if ((top == '0) || (top == '1))
        begin
            return v[VAL_W-1:0];
        end
        return v[SUM_W-1] ? SAT_NEG : SAT_POS;
    endfunction

    always_comb
    begin
        lo_sum = SUM_W'($signed(prod.offset));
        hi_sum = lo_sum;
        pa = '0;
        pb = '0;
        ta = '0;
        tb = '0;
        for (int i = 0; i < NAXES; i++)
        begin
            // round to nearest, ties up: floor((p + 2^15) / 2^16)
            pa = $signed(prod.pmin[i]) + $signed(ROUND_HALF);
            pb = $signed(prod.pmax[i]) + $signed(ROUND_HALF);
            ta = pa[PROD_W-1:FRAC_W];
            tb = pb[PROD_W-1:FRAC_W];
            if (ta < tb)
            begin
                lo_sum = lo_sum + SUM_W'(ta);
                hi_sum = hi_sum + SUM_W'(tb);
            end
            else
            begin
                lo_sum = lo_sum + SUM_W'(tb);
                hi_sum = hi_sum + SUM_W'(ta);
            end
        end
        rng_next.valid  = prod.valid;
        rng_next.row    = prod.row;
        rng_next.last   = prod.last;
        rng_next.box_ok = prod.box_ok;
        rng_next.lo     = sat32(lo_sum);
        rng_next.hi     = sat32(hi_sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rng_reg <= '0;
        end
        else if (advance)
        begin
            rng_reg <= rng_next;
        end
    end

    assign rng = rng_reg;

endmodule

// File: rtl/taabb_accum.sv
module taabb_accum
    import taabb_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  range_t rng,
    output logic   advance,
    output logic   m_axis_tvalid,
    input  logic   m_axis_tready,
    output logic [6*VAL_W-1:0] m_axis_tdata,   // min_x, min_y, min_z, max_x, max_y, max_z
    output logic   m_axis_tuser                 // bounds_valid
);

    vec_t bmin_reg;
    vec_t bmin_next;
    vec_t bmax_reg;
    vec_t bmax_next;
    logic have_reg;
    logic have_next;

    logic out_valid_reg;
    logic out_valid_next;
    logic [6*VAL_W-1:0] out_data_reg;
    logic [6*VAL_W-1:0] out_data_next;
    logic out_flag_reg;
    logic out_flag_next;

    vec_t mmin;
    vec_t mmax;
    logic mhave;
    logic emit;
    logic fire;

    assign emit    = (rng.row == ROW_Z) && rng.last;
    assign advance = !(rng.valid && emit && out_valid_reg && !m_axis_tready);
    assign fire    = rng.valid && advance;

    always_comb
    begin
        mmin  = bmin_reg;
        mmax  = bmax_reg;
        mhave = have_reg;
        if (fire && rng.box_ok)
        begin
            if (!have_reg)
            begin
                mmin[rng.row] = rng.lo;
                mmax[rng.row] = rng.hi;
            end
            else
            begin
                if ($signed(rng.lo) < $signed(bmin_reg[rng.row]))
                begin
                    mmin[rng.row] = rng.lo;
                end
                if ($signed(rng.hi) > $signed(bmax_reg[rng.row]))
                begin
                    mmax[rng.row] = rng.hi;
                end
            end
            if (rng.row == ROW_Z)
            begin
                mhave = 1'b1;
            end
        end

        bmin_next      = mmin;
        bmax_next      = mmax;
        have_next      = mhave;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        out_flag_next  = out_flag_reg;

        if (fire && emit)
        begin
            out_valid_next = 1'b1;
            out_flag_next  = mhave;
            out_data_next  = mhave ? {mmax, mmin} : '0;
            bmin_next      = '0;
            bmax_next      = '0;
            have_next      = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bmin_reg      <= '0;
            bmax_reg      <= '0;
            have_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            bmin_reg      <= bmin_next;
            bmax_reg      <= bmax_next;
            have_reg      <= have_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_flag_reg <= out_flag_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_flag_reg;

`ifndef ASSERT_OFF
    a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && emit) |=> (!have_reg && (bmin_reg == '0) && (bmax_reg == '0)))
        else $error("bounds not cleared after emit");

    a_empty_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("empty bounds carry nonzero data");

    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
            (($signed(m_axis_tdata[VAL_W-1:0]) <= $signed(m_axis_tdata[4*VAL_W-1:3*VAL_W]))
            && ($signed(m_axis_tdata[2*VAL_W-1:VAL_W])
                <= $signed(m_axis_tdata[5*VAL_W-1:4*VAL_W]))
            && ($signed(m_axis_tdata[3*VAL_W-1:2*VAL_W])
                <= $signed(m_axis_tdata[6*VAL_W-1:5*VAL_W]))))
        else $error("emitted min above max");

    a_stall_only_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |-> (rng.valid && emit && out_valid_reg))
        else $error("pipeline stalled without pending emit");
`endif

endmodule

// File: rtl/transformed_aabb_bounds.sv
// Throughput: one row per cycle when not stalled; input register, product stage, rounding/sum
// stage, then merge into the running bounds and the output register.
// Stall: only a closing row (row 2, tlast) meeting a full, untaken output register.
// Reset (rst_n low, async): box registers, bounds and the pipeline valid flags go to zero.
module transformed_aabb_bounds
    import taabb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // coef_x, coef_y, coef_z, offset
    input  logic [1:0]   s_axis_tuser,   // row_index
    input  logic         s_axis_tlast,   // last_instance
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [191:0] m_axis_tdata,   // min_x, min_y, min_z, max_x, max_y, max_z
    output logic         m_axis_tuser,   // bounds_valid
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    vec_t lmin_reg;
    vec_t lmin_next;
    vec_t lmax_reg;
    vec_t lmax_next;

    row_req_t req_reg;
    row_req_t req_next;

    prod_t  prod;
    range_t rng;
    logic   advance;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = advance;

    always_comb
    begin
        lmin_next = lmin_reg;
        lmax_next = lmax_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MIN_X: lmin_next[0] = cfg_data;
                REG_MIN_Y: lmin_next[1] = cfg_data;
                REG_MIN_Z: lmin_next[2] = cfg_data;
                REG_MAX_X: lmax_next[0] = cfg_data;
                REG_MAX_Y: lmax_next[1] = cfg_data;
                REG_MAX_Z: lmax_next[2] = cfg_data;
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        req_next.valid  = s_axis_tvalid;
        req_next.row    = s_axis_tuser;
        req_next.last   = s_axis_tlast;
        req_next.coef   = s_axis_tdata[3*VAL_W-1:0];
        req_next.offset = s_axis_tdata[4*VAL_W-1:3*VAL_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lmin_reg <= '0;
            lmax_reg <= '0;
            req_reg  <= '0;
        end
        else
        begin
            lmin_reg <= lmin_next;
            lmax_reg <= lmax_next;
            if (advance)
            begin
                req_reg <= req_next;
            end
        end
    end

    taabb_mult u_mult (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .req       (req_reg),
        .local_min (lmin_reg),
        .local_max (lmax_reg),
        .prod      (prod)
    );

    taabb_reduce u_reduce (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .prod    (prod),
        .rng     (rng)
    );

    taabb_accum u_accum (
        .clk           (clk),
        .rst_n         (rst_n),
        .rng           (rng),
        .advance       (advance),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
